/* hw/rtl/bmp565_pkg.sv */
package bmp565_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_TOO_SMALL   = 3'd1;
   localparam logic [2:0] ERR_SIGNATURE   = 3'd2;
   localparam logic [2:0] ERR_DEPTH       = 3'd3;
   localparam logic [2:0] ERR_COMPRESSED  = 3'd4;
   localparam logic [2:0] ERR_OFFSET_LOW  = 3'd5;

   // Header layout and limits.
   localparam logic [31:0] MIN_FILE_SIZE   = 32'd54;
   localparam logic [31:0] MIN_DATA_OFFSET = 32'd34;
   localparam logic [15:0] DEPTH_24        = 16'd24;
   localparam logic [7:0]  SIG_BYTE0       = 8'h42;
   localparam logic [7:0]  SIG_BYTE1       = 8'h4D;

   localparam logic [31:0] POS_SIG0       = 32'd0;
   localparam logic [31:0] POS_SIG1       = 32'd1;
   localparam logic [31:0] POS_OFS_FIRST  = 32'd10;
   localparam logic [31:0] POS_OFS_LAST   = 32'd13;
   localparam logic [31:0] POS_WIDTH_LO   = 32'd18;
   localparam logic [31:0] POS_WIDTH_HI   = 32'd19;
   localparam logic [31:0] POS_HEIGHT_LO  = 32'd22;
   localparam logic [31:0] POS_HEIGHT_HI  = 32'd23;
   localparam logic [31:0] POS_DEPTH_LO   = 32'd28;
   localparam logic [31:0] POS_DEPTH_HI   = 32'd29;
   localparam logic [31:0] POS_COMP_FIRST = 32'd30;
   localparam logic [31:0] POS_COMP_LAST  = 32'd33;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [2:0]  error_code;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [15:0] bits_per_pixel;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [15:0] color_565;
      logic [32:0] byte_address;
      logic        last_result;
   } rsp_type;

endpackage

/* hw/rtl/bmp24_to_rgb565_stream.sv */
// Parses a 24-bit BMP file presented one byte per beat and returns one header beat, the
// converted RGB565 pixels with their top-down buffer addresses, or an error beat. Every
// byte is taken while req_stall is low, for a sustained rate of one byte per clock; the
// path that sets the clock is the 16x16 row-base multiply plus the address add. Results
// sit in an output register backed by one skid entry, and req_stall rises only when
// both hold a beat. Write csr_write_data (file size) before the first byte of a file.
module bmp24_to_rgb565_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_file_byte,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [2:0]  rsp_error_code,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [15:0] rsp_bits_per_pixel,
   output logic [15:0] rsp_pixel_x,
   output logic [15:0] rsp_pixel_y,
   output logic [15:0] rsp_color_565,
   output logic [32:0] rsp_byte_address,
   output logic        rsp_last_result
);
   import bmp565_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_SKIP   = 3'd2;
   localparam logic [2:0] PH_PIXEL  = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   logic [31:0] file_size_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] byte_pos_ff, byte_pos_in;
   logic [31:0] offset_ff, offset_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [15:0] depth_ff, depth_in;
   logic        comp_nz_ff, comp_nz_in;
   logic [17:0] row_count_ff, row_count_in;
   logic [1:0]  comp_ff, comp_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] dest_row_ff, dest_row_in;
   logic [15:0] pbg_ff, pbg_in;

   rsp_type     rsp_ff, skid_ff, res;
   logic        rsp_valid_ff, skid_valid_ff, res_valid;

   logic        accept, take;
   logic [31:0] pos;
   logic [2:0]  cur_phase;
   logic        pixel_step;
   logic [1:0]  ofs_idx;
   logic [17:0] data_bytes, row_size, row_next;
   logic [31:0] row_base;
   logic        pixel_last;

   assign accept = req_valid && !req_stall;
   assign take   = rsp_valid_ff && !rsp_stall;

   // Row geometry: three bytes per pixel, each row padded to a multiple of four bytes.
   assign data_bytes = {1'b0, width_ff, 1'b0} + {2'b00, width_ff};
   assign row_size   = (data_bytes + 18'd3) & ~18'd3;
   assign row_next   = row_count_ff + 18'd1;
   assign row_base   = {16'd0, dest_row_ff} * {16'd0, width_ff};
   assign pixel_last = (dest_row_ff == 16'd0) &&
                       ({1'b0, col_ff} + 17'd1 == {1'b0, width_ff});
   assign ofs_idx    = 2'(pos[1:0] - 2'd2);

   always_comb begin
      phase_in     = phase_ff;
      byte_pos_in  = byte_pos_ff;
      offset_in    = offset_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      depth_in     = depth_ff;
      comp_nz_in   = comp_nz_ff;
      row_count_in = row_count_ff;
      comp_in      = comp_ff;
      col_in       = col_ff;
      dest_row_in  = dest_row_ff;
      pbg_in       = pbg_ff;
      res          = '0;
      res_valid    = 1'b0;
      pixel_step   = 1'b0;
      pos          = req_start_of_file ? 32'd0 : byte_pos_ff;
      cur_phase    = req_start_of_file ? PH_HEADER : phase_ff;

      if (accept) begin
         if (req_start_of_file) begin
            offset_in    = '0;
            width_in     = '0;
            height_in    = '0;
            depth_in     = '0;
            comp_nz_in   = 1'b0;
            row_count_in = '0;
            comp_in      = '0;
            col_in       = '0;
            dest_row_in  = '0;
            pbg_in       = '0;
            phase_in     = PH_HEADER;
         end
         byte_pos_in = (pos == '1) ? pos : pos + 32'd1;

         if (req_start_of_file && file_size_ff < MIN_FILE_SIZE) begin
            phase_in        = PH_DONE;
            res_valid       = 1'b1;
            res.result_kind = KIND_ERROR;
            res.error_code  = ERR_TOO_SMALL;
            res.last_result = 1'b1;
         end else begin
            unique case (cur_phase)
               PH_HEADER: begin
                  priority if (pos == POS_SIG0) begin
                     pbg_in = {8'd0, req_file_byte};
                  end else if (pos == POS_SIG1) begin
                     if (!(pbg_ff == {8'd0, SIG_BYTE0} && req_file_byte == SIG_BYTE1)) begin
                        phase_in        = PH_DONE;
                        res_valid       = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.error_code  = ERR_SIGNATURE;
                        res.last_result = 1'b1;
                     end
                  end else if (pos >= POS_OFS_FIRST && pos <= POS_OFS_LAST) begin
                     offset_in[{ofs_idx, 3'b000} +: 8] =
                        offset_in[{ofs_idx, 3'b000} +: 8] | req_file_byte;
                  end else if (pos == POS_WIDTH_LO) begin
                     width_in[7:0] = width_in[7:0] | req_file_byte;
                  end else if (pos == POS_WIDTH_HI) begin
                     width_in[15:8] = width_in[15:8] | req_file_byte;
                  end else if (pos == POS_HEIGHT_LO) begin
                     height_in[7:0] = height_in[7:0] | req_file_byte;
                  end else if (pos == POS_HEIGHT_HI) begin
                     height_in[15:8] = height_in[15:8] | req_file_byte;
                  end else if (pos == POS_DEPTH_LO) begin
                     depth_in = {8'd0, req_file_byte};
                  end else if (pos == POS_DEPTH_HI) begin
                     depth_in[15:8] = depth_in[15:8] | req_file_byte;
                     if (depth_in != DEPTH_24) begin
                        phase_in        = PH_DONE;
                        res_valid       = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.error_code  = ERR_DEPTH;
                        res.last_result = 1'b1;
                     end
                  end else if (pos >= POS_COMP_FIRST && pos <= POS_COMP_LAST) begin
                     if (req_file_byte != 8'd0) begin
                        comp_nz_in = 1'b1;
                     end
                     if (pos == POS_COMP_LAST) begin
                        res_valid       = 1'b1;
                        res.last_result = 1'b1;
                        priority if (comp_nz_in) begin
                           phase_in        = PH_DONE;
                           res.result_kind = KIND_ERROR;
                           res.error_code  = ERR_COMPRESSED;
                        end else if (offset_in < MIN_DATA_OFFSET) begin
                           phase_in        = PH_DONE;
                           res.result_kind = KIND_ERROR;
                           res.error_code  = ERR_OFFSET_LOW;
                        end else begin
                           res.result_kind = KIND_HEADER;
                           pbg_in          = '0;
                           row_count_in    = '0;
                           comp_in         = '0;
                           col_in          = '0;
                           if (width_in == 16'd0 || height_in == 16'd0) begin
                              phase_in = PH_DONE;
                           end else begin
                              dest_row_in     = height_in - 16'd1;
                              phase_in        = PH_SKIP;
                              res.last_result = 1'b0;
                           end
                        end
                     end
                  end else begin
                     pbg_in = pbg_in;
                  end
               end
               PH_SKIP: begin
                  if (pos >= offset_ff) begin
                     phase_in   = PH_PIXEL;
                     pixel_step = 1'b1;
                  end
               end
               PH_PIXEL: pixel_step = 1'b1;
               default: pixel_step = 1'b0;
            endcase
         end

         if (pixel_step) begin
            row_count_in = row_next;
            if (row_count_ff < data_bytes) begin
               unique case (comp_ff)
                  2'd0: begin
                     pbg_in  = {8'd0, req_file_byte};
                     comp_in = 2'd1;
                  end
                  2'd1: begin
                     pbg_in  = {req_file_byte, pbg_ff[7:0]};
                     comp_in = 2'd2;
                  end
                  2'd2: begin
                     comp_in          = 2'd0;
                     col_in           = col_ff + 16'd1;
                     res_valid        = 1'b1;
                     res.result_kind  = KIND_PIXEL;
                     res.pixel_x      = col_ff;
                     res.pixel_y      = dest_row_ff;
                     res.color_565    = {req_file_byte[7:3], pbg_ff[15:10], pbg_ff[7:3]};
                     res.byte_address = {row_base + {16'd0, col_ff}, 1'b0};
                     res.last_result  = pixel_last;
                  end
                  default: comp_in = 2'd0;
               endcase
            end
            if (res_valid && pixel_last) begin
               // The final pixel ends the file; counters are left where they were.
               phase_in     = PH_DONE;
               row_count_in = row_count_ff;
               comp_in      = comp_ff;
               col_in       = col_ff;
            end else if (row_next >= row_size) begin
               row_count_in = '0;
               comp_in      = '0;
               col_in       = '0;
               dest_row_in  = dest_row_ff - 16'd1;
            end
         end

         if (res_valid) begin
            res.image_width    = width_in;
            res.image_height   = height_in;
            res.bits_per_pixel = depth_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff  <= '0;
         phase_ff      <= PH_IDLE;
         byte_pos_ff   <= '0;
         offset_ff     <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         depth_ff      <= '0;
         comp_nz_ff    <= 1'b0;
         row_count_ff  <= '0;
         comp_ff       <= '0;
         col_ff        <= '0;
         dest_row_ff   <= '0;
         pbg_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            file_size_ff <= csr_write_data;
         end
         phase_ff     <= phase_in;
         byte_pos_ff  <= byte_pos_in;
         offset_ff    <= offset_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         depth_ff     <= depth_in;
         comp_nz_ff   <= comp_nz_in;
         row_count_ff <= row_count_in;
         comp_ff      <= comp_in;
         col_ff       <= col_in;
         dest_row_ff  <= dest_row_in;
         pbg_ff       <= pbg_in;

         // The skid entry only fills while the output register is full and stalled.
         if (skid_valid_ff) begin
            if (take) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (!rsp_valid_ff || take) begin
            rsp_valid_ff <= res_valid;
         end else if (res_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            rsp_ff <= skid_ff;
         end
      end else if (!rsp_valid_ff || take) begin
         rsp_ff <= res;
      end else if (res_valid) begin
         skid_ff <= res;
      end
   end

   assign req_stall          = skid_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_ff.result_kind;
   assign rsp_error_code     = rsp_ff.error_code;
   assign rsp_image_width    = rsp_ff.image_width;
   assign rsp_image_height   = rsp_ff.image_height;
   assign rsp_bits_per_pixel = rsp_ff.bits_per_pixel;
   assign rsp_pixel_x        = rsp_ff.pixel_x;
   assign rsp_pixel_y        = rsp_ff.pixel_y;
   assign rsp_color_565      = rsp_ff.color_565;
   assign rsp_byte_address   = rsp_ff.byte_address;
   assign rsp_last_result    = rsp_ff.last_result;

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds a beat while the output register is empty");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.result_kind == KIND_ERROR) |->
         (rsp_ff.error_code != ERR_NONE && rsp_ff.last_result))
      else $error("error beat without an error code or without last_result");

   a_code_only_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.result_kind != KIND_ERROR) |-> rsp_ff.error_code == ERR_NONE)
      else $error("error code set on a non-error beat");

   a_small_file_reports: assert property (@(posedge clock) disable iff (reset)
      (accept && req_start_of_file && file_size_ff < MIN_FILE_SIZE) |=> rsp_valid_ff)
      else $error("undersized file did not produce a result beat");

endmodule

/* bench/tb.sv */
module tb;
   import bmp565_pkg::*;

   typedef enum logic [2:0] {
      PARSE_IDLE, PARSE_HEADER, PARSE_SKIP, PARSE_PIXEL, PARSE_DONE
   } parse_state_type;

   typedef struct {
      logic [7:0] data;
      logic       sof;
   } file_item_type;

   localparam longint WHOLE_FILE = 64'd1 << 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_file_byte = '0;
   logic        req_start_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [1:0]  rsp_result_kind;
   logic [2:0]  rsp_error_code;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic [15:0] rsp_bits_per_pixel;
   logic [15:0] rsp_pixel_x;
   logic [15:0] rsp_pixel_y;
   logic [15:0] rsp_color_565;
   logic [32:0] rsp_byte_address;
   logic        rsp_last_result;

   bmp24_to_rgb565_stream DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_file_byte      (req_file_byte),
      .req_start_of_file  (req_start_of_file),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_error_code     (rsp_error_code),
      .rsp_image_width    (rsp_image_width),
      .rsp_image_height   (rsp_image_height),
      .rsp_bits_per_pixel (rsp_bits_per_pixel),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_y        (rsp_pixel_y),
      .rsp_color_565      (rsp_color_565),
      .rsp_byte_address   (rsp_byte_address),
      .rsp_last_result    (rsp_last_result)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   file_item_type file_bytes_q[$];
   rsp_type       expected_results[$];
   file_item_type head_byte;
   rsp_type       seen_result;

   int send_idle_pct = 13;
   int recv_idle_pct = 57;
   logic start_long_hold = 1'b0;
   int hold_left = 0;

   int bytes_queued = 0;
   int bytes_accepted = 0;
   int settings_written = 0;
   int mismatches = 0;
   int beats_seen = 0;
   int pixels_seen = 0;
   int headers_seen = 0;
   int errors_seen = 0;

   // Decoder state as the block should hold it.
   logic [31:0]     size_setting = '0;
   logic [31:0]     byte_count = '0;
   parse_state_type parse_state = PARSE_IDLE;
   logic [31:0]     data_offset = '0;
   logic [15:0]     hdr_width = '0;
   logic [15:0]     hdr_height = '0;
   logic [15:0]     hdr_depth = '0;
   logic            comp_seen = 1'b0;
   logic [31:0]     row_bytes = '0;
   logic [15:0]     row_dest = '0;
   logic [15:0]     blue_green = '0;

   function automatic void push_result(logic [1:0] kind, logic [2:0] code, logic [15:0] x,
                                       logic [15:0] y, logic [15:0] color,
                                       logic [32:0] addr, logic last);
      rsp_type r;
      r.result_kind    = kind;
      r.error_code     = code;
      r.image_width    = hdr_width;
      r.image_height   = hdr_height;
      r.bits_per_pixel = hdr_depth;
      r.pixel_x        = x;
      r.pixel_y        = y;
      r.color_565      = color;
      r.byte_address   = addr;
      r.last_result    = last;
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void report_error(logic [2:0] code);
      parse_state = PARSE_DONE;
      push_result(KIND_ERROR, code, '0, '0, '0, '0, 1'b1);
   endfunction

   function automatic void parse_header(logic [31:0] p, logic [7:0] b);
      if (p == POS_SIG0) begin
         blue_green = {8'h00, b};
      end else if (p == POS_SIG1) begin
         if (!(blue_green == {8'h00, SIG_BYTE0} && b == SIG_BYTE1))
            report_error(ERR_SIGNATURE);
      end else if (p >= POS_OFS_FIRST && p <= POS_OFS_LAST) begin
         data_offset = data_offset | (32'(b) << (8 * (p - POS_OFS_FIRST)));
      end else if (p == POS_WIDTH_LO) begin
         hdr_width[7:0] = b;
      end else if (p == POS_WIDTH_HI) begin
         hdr_width[15:8] = b;
      end else if (p == POS_HEIGHT_LO) begin
         hdr_height[7:0] = b;
      end else if (p == POS_HEIGHT_HI) begin
         hdr_height[15:8] = b;
      end else if (p == POS_DEPTH_LO) begin
         hdr_depth = {8'h00, b};
      end else if (p == POS_DEPTH_HI) begin
         hdr_depth[15:8] = b;
         if (hdr_depth != DEPTH_24)
            report_error(ERR_DEPTH);
      end else if (p >= POS_COMP_FIRST && p <= POS_COMP_LAST) begin
         if (b != 8'h00)
            comp_seen = 1'b1;
         if (p == POS_COMP_LAST) begin
            // The compression check wins over the offset check.
            if (comp_seen) begin
               report_error(ERR_COMPRESSED);
            end else if (data_offset < MIN_DATA_OFFSET) begin
               report_error(ERR_OFFSET_LOW);
            end else begin
               blue_green = '0;
               row_bytes = '0;
               if (hdr_width == 0 || hdr_height == 0) begin
                  parse_state = PARSE_DONE;
                  push_result(KIND_HEADER, ERR_NONE, '0, '0, '0, '0, 1'b1);
               end else begin
                  row_dest = hdr_height - 16'd1;
                  parse_state = PARSE_SKIP;
                  push_result(KIND_HEADER, ERR_NONE, '0, '0, '0, '0, 1'b0);
               end
            end
         end
      end
   endfunction

   function automatic void parse_pixel(logic [7:0] b);
      logic [31:0] data_bytes;
      logic [31:0] row_size;
      logic [31:0] col;
      logic [15:0] color;
      logic [32:0] addr;
      logic        last;
      data_bytes = 32'(hdr_width) * 32'd3;
      row_size = (data_bytes + 32'd3) & ~32'd3;
      if (row_bytes < data_bytes) begin
         case (row_bytes % 32'd3)
            32'd0: blue_green = {8'h00, b};
            32'd1: blue_green[15:8] = b;
            default: begin
               color = {b[7:3], blue_green[15:10], blue_green[7:3]};
               col = row_bytes / 32'd3;
               addr = (33'(row_dest) * 33'(hdr_width) + 33'(col)) * 33'd2;
               last = (row_dest == 0) && (col + 32'd1 == 32'(hdr_width));
               push_result(KIND_PIXEL, ERR_NONE, col[15:0], row_dest, color, addr, last);
               if (last) begin
                  parse_state = PARSE_DONE;
                  return;
               end
            end
         endcase
      end
      row_bytes = row_bytes + 32'd1;
      if (row_bytes >= row_size) begin
         row_bytes = '0;
         row_dest = row_dest - 16'd1;
      end
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic sof);
      logic [31:0] p;
      if (sof) begin
         p = '0;
         data_offset = '0;
         hdr_width = '0;
         hdr_height = '0;
         hdr_depth = '0;
         comp_seen = 1'b0;
         row_bytes = '0;
         row_dest = '0;
         blue_green = '0;
         parse_state = PARSE_HEADER;
      end else begin
         p = byte_count;
      end
      byte_count = (p == 32'hFFFF_FFFF) ? p : p + 32'd1;
      if (sof && size_setting < MIN_FILE_SIZE) begin
         report_error(ERR_TOO_SMALL);
         return;
      end
      case (parse_state)
         PARSE_HEADER: parse_header(p, b);
         PARSE_SKIP: begin
            if (p >= data_offset) begin
               parse_state = PARSE_PIXEL;
               parse_pixel(b);
            end
         end
         PARSE_PIXEL: parse_pixel(b);
         default: ;
      endcase
   endfunction

   // Sender: one byte per beat, with random gaps between beats.
   always @(posedge clock) begin
      if (csr_write_enable)
         size_setting = csr_write_data;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_file_byte, req_start_of_file);
            bytes_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (file_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               head_byte = file_bytes_q.pop_front();
               req_valid <= 1'b1;
               req_file_byte <= head_byte.data;
               req_start_of_file <= head_byte.sof;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (start_long_hold) begin
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic void check_field(string name, logic [32:0] want, logic [32:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch in %s on result beat %0d: expected %h, got %h",
                     name, beats_seen, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Result beat %0d arrived with nothing expected (kind %h)",
                        beats_seen, rsp_result_kind);
         end else begin
            seen_result = expected_results.pop_front();
            check_field("result_kind", 33'(seen_result.result_kind), 33'(rsp_result_kind));
            check_field("error_code", 33'(seen_result.error_code), 33'(rsp_error_code));
            check_field("image_width", 33'(seen_result.image_width), 33'(rsp_image_width));
            check_field("image_height", 33'(seen_result.image_height),
                        33'(rsp_image_height));
            check_field("bits_per_pixel", 33'(seen_result.bits_per_pixel),
                        33'(rsp_bits_per_pixel));
            check_field("pixel_x", 33'(seen_result.pixel_x), 33'(rsp_pixel_x));
            check_field("pixel_y", 33'(seen_result.pixel_y), 33'(rsp_pixel_y));
            check_field("color_565", 33'(seen_result.color_565), 33'(rsp_color_565));
            check_field("byte_address", seen_result.byte_address, rsp_byte_address);
            check_field("last_result", 33'(seen_result.last_result), 33'(rsp_last_result));
            case (seen_result.result_kind)
               KIND_PIXEL:  pixels_seen++;
               KIND_HEADER: headers_seen++;
               default:     errors_seen++;
            endcase
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic sof);
      file_item_type item;
      item.data = b;
      item.sof = sof;
      file_bytes_q.insert(file_bytes_q.size(), item);
      bytes_queued++;
   endtask

   // Builds a file with the given header fields and random filler and pixel data,
   // cut short after the given number of bytes.
   task automatic queue_bmp(input logic [7:0] sig0, input logic [7:0] sig1,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] depth, input logic [31:0] comp,
                            input logic [31:0] ofs, input longint cut);
      longint row_size;
      longint full_len;
      longint n;
      longint p;
      logic [7:0] b;
      row_size = (longint'(w) * 3 + 3) / 4 * 4;
      full_len = ((ofs > MIN_DATA_OFFSET) ? longint'(ofs) : longint'(MIN_DATA_OFFSET))
                 + longint'(h) * row_size;
      n = (cut < full_len) ? cut : full_len;
      for (p = 0; p < n; p++) begin
         if (p == POS_SIG0)
            b = sig0;
         else if (p == POS_SIG1)
            b = sig1;
         else if (p >= POS_OFS_FIRST && p <= POS_OFS_LAST)
            b = 8'(ofs >> (8 * (p - POS_OFS_FIRST)));
         else if (p == POS_WIDTH_LO)
            b = w[7:0];
         else if (p == POS_WIDTH_HI)
            b = w[15:8];
         else if (p == POS_HEIGHT_LO)
            b = h[7:0];
         else if (p == POS_HEIGHT_HI)
            b = h[15:8];
         else if (p == POS_DEPTH_LO)
            b = depth[7:0];
         else if (p == POS_DEPTH_HI)
            b = depth[15:8];
         else if (p >= POS_COMP_FIRST && p <= POS_COMP_LAST)
            b = 8'(comp >> (8 * (p - POS_COMP_FIRST)));
         else
            b = 8'($urandom);
         queue_byte(b, p == 0);
      end
   endtask

   task automatic queue_good(input logic [15:0] w, input logic [15:0] h,
                             input logic [31:0] ofs, input longint cut);
      queue_bmp(SIG_BYTE0, SIG_BYTE1, w, h, DEPTH_24, '0, ofs, cut);
   endtask

   task automatic queue_random_file();
      int pick;
      logic [31:0] ofs;
      logic [15:0] w;
      logic [15:0] h;
      longint cut;
      pick = $urandom_range(99);
      ofs = $urandom_range(60, 34);
      w = 16'($urandom_range(6, 1));
      h = 16'($urandom_range(4, 1));
      cut = ($urandom_range(9) == 0) ? longint'($urandom_range(80, 1)) : WHOLE_FILE;
      if (pick < 70) begin
         queue_good(w, h, ofs, cut);
      end else if (pick < 78) begin
         // Large images are cut after a few pixels of the bottom row.
         ofs = $urandom_range(40, 34);
         queue_good(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)), ofs,
                    longint'(ofs) + longint'($urandom_range(30)));
      end else if (pick < 90) begin
         cut = longint'(34 + $urandom_range(10));
         case ($urandom_range(5))
            0: queue_bmp(8'($urandom), 8'($urandom), w, h, DEPTH_24, '0, ofs, cut);
            1: queue_bmp(SIG_BYTE0, SIG_BYTE1, w, h, 16'($urandom), '0, ofs, cut);
            2: queue_bmp(SIG_BYTE0, SIG_BYTE1, w, h, DEPTH_24, 32'd1 << $urandom_range(31),
                         ofs, cut);
            3: queue_good(w, h, $urandom_range(33), cut);
            4: queue_good($urandom_range(1) ? 16'd0 : w, $urandom_range(1) ? h : 16'd0,
                          ofs, cut);
            default: queue_good(w, h, $urandom, cut);
         endcase
      end else begin
         repeat ($urandom_range(20, 1))
            queue_byte(8'($urandom), $urandom_range(9) == 0);
      end
   endtask

   // Waits until every byte is taken and every result has come back.
   task automatic drain();
      while (file_bytes_q.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_size(input logic [31:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_written++;
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct, input logic long_hold);
      int start_count;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start_count = bytes_queued;
      if (long_hold) begin
         queue_good(16'd6, 16'd4, 32'd40, WHOLE_FILE);
         @(posedge clock);
         start_long_hold <= 1'b1;
         @(posedge clock);
         start_long_hold <= 1'b0;
      end
      while (bytes_queued - start_count < 430)
         queue_random_file();
      drain();
   endtask

   initial begin
      int guard;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Bytes before any start of file are dropped.
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      drain();
      write_size('0);
      queue_good(16'd1, 16'd1, 32'd54, 3);
      drain();
      write_size(MIN_FILE_SIZE - 32'd1);
      queue_good(16'd1, 16'd1, 32'd54, 2);
      drain();
      write_size(MIN_FILE_SIZE);

      queue_bmp(8'h43, SIG_BYTE1, 16'd1, 16'd1, DEPTH_24, '0, 32'd54, 4);
      queue_bmp(SIG_BYTE0, 8'h4C, 16'd1, 16'd1, DEPTH_24, '0, 32'd54, 4);
      queue_bmp(SIG_BYTE0, SIG_BYTE1, 16'd1, 16'd1, 16'd32, '0, 32'd54, 34);
      queue_bmp(SIG_BYTE0, SIG_BYTE1, 16'd1, 16'd1, 16'h0118, '0, 32'd54, 34);
      queue_bmp(SIG_BYTE0, SIG_BYTE1, 16'd1, 16'd1, DEPTH_24, 32'h0100_0000, 32'd54, 34);
      queue_bmp(SIG_BYTE0, SIG_BYTE1, 16'd1, 16'd1, DEPTH_24, 32'd1, 32'd0, 34);
      queue_good(16'd1, 16'd1, MIN_DATA_OFFSET - 32'd1, WHOLE_FILE);
      queue_good(16'd0, 16'd3, 32'd34, WHOLE_FILE);
      queue_good(16'd2, 16'd0, 32'd34, WHOLE_FILE);
      queue_good(16'd1, 16'd1, 32'd54, WHOLE_FILE);
      queue_good(16'd3, 16'd2, 32'd34, WHOLE_FILE);
      queue_good(16'd4, 16'd2, 32'd36, WHOLE_FILE);
      // A restart in the middle of the pixel data.
      queue_good(16'd5, 16'd3, 32'd34, 50);
      queue_good(16'hFFFF, 16'hFFFF, 32'd34, 43);
      queue_good(16'd2, 16'd2, 32'hFFFF_FFFF, 40);
      drain();

      write_size(32'hFFFF_FFFF);
      random_phase(13, 57, 1'b0);
      write_size($urandom_range(32'hFFFF_FFFE, 32'd55));
      random_phase(57, 13, 1'b1);
      write_size(MIN_FILE_SIZE);
      random_phase(0, 0, 1'b0);

      guard = 0;
      while (expected_results.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (16) @(posedge clock);
      if (expected_results.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", expected_results.size());
      end
      $display("Streamed %0d file bytes under %0d size register settings.",
               bytes_accepted, settings_written);
      $display("Checked %0d pixels, %0d header results and %0d error results.",
               pixels_seen, headers_seen, errors_seen);
      if (mismatches == 0)
         $display("bmp24_to_rgb565_stream test passed");
      else
         $display("bmp24_to_rgb565_stream test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d results outstanding", expected_results.size());
      $display("bmp24_to_rgb565_stream test failed");
      $finish;
   end

endmodule
